FILE: hw/rtl/eshex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence hex encoder package
// Shared types, character constants and the hex digit helper.
// ----------------------------------------------------------------------------
package eshex_pkg;

    // Escape decoding phases.
    typedef enum logic [2:0] {
        PH_PLAIN  = 3'd0,
        PH_BSLASH = 3'd1,
        PH_RAW1   = 3'd2,
        PH_RAW2   = 3'd3,
        PH_OCT1   = 3'd4,
        PH_OCT2   = 3'd5
    } eshex_phase_t;

    // Most characters that one input byte can produce.
    localparam int unsigned MAX_CHARS = 4;

    // Character codes.
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_ALPHA_OFS = 8'h37;  // 'A' - 10
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_UPPER_X   = 8'h58;
    localparam logic [7:0] CODE_NEWLINE = 8'h0A;
    localparam logic [7:0] CODE_TAB     = 8'h09;

    // Group of characters produced by one accepted byte.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [2:0]                count;
        logic                      text_end;
    } eshex_group_t;

    // Uppercase hex digit for a nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] v8;
        v8 = {4'd0, v};
        if (v < 4'd10)
        begin
            return CH_ZERO + v8;
        end
        return CH_ALPHA_OFS + v8;
    endfunction

    // Two hex digits for a byte, high nibble in the upper half.
    function automatic logic [15:0] hex_pair(input logic [7:0] b);
        return {hex_digit(b[7:4]), hex_digit(b[3:0])};
    endfunction

endpackage

FILE: hw/rtl/eshex_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped text channel
// Valid/ready channel that carries one byte of escaped text per transfer.
// ----------------------------------------------------------------------------
interface eshex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       text_end;

    modport source (output valid, output in_char, output text_end, input ready);
    modport sink   (input valid, input in_char, input text_end, output ready);
endinterface

FILE: hw/rtl/eshex_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex character channel
// Valid/ready channel that carries one output character per transfer.
// ----------------------------------------------------------------------------
interface eshex_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_last;
    logic       text_last;

    modport source (output valid, output out_char, output run_last, output text_last,
                    input ready);
    modport sink   (input valid, input out_char, input run_last, input text_last,
                    output ready);
endinterface

FILE: hw/rtl/eshex_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape decoder
// Holds the escape phase and the octal code, and turns one accepted byte
// into a group of zero to four output characters.
// ----------------------------------------------------------------------------
module eshex_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            in_char,
    input  logic                  text_end,
    output eshex_pkg::eshex_group_t group
);
    import eshex_pkg::*;

    eshex_phase_t phase_reg, phase_next;
    logic [5:0]   code_reg, code_next;

    logic         is_octal;
    logic [2:0]   digit;
    logic [15:0]  hex_in;
    logic [15:0]  hex_code;
    logic [15:0]  hex_third;
    logic [15:0]  hex_flush;
    eshex_phase_t phase_mid;
    logic [5:0]   code_mid;

    assign is_octal  = (in_char[7:3] == CH_ZERO[7:3]);
    assign digit     = in_char[2:0];
    assign hex_in    = hex_pair(in_char);
    assign hex_code  = hex_pair({2'b00, code_reg});
    // A third digit completes the code; only its low 8 bits are kept.
    assign hex_third = hex_pair({code_reg[4:0], digit});
    assign hex_flush = hex_pair({2'b00, code_mid});

    // Character production and phase transition for the byte.
    always_comb
    begin
        group.chars    = '0;
        group.count    = 3'd0;
        group.text_end = text_end;
        phase_mid      = phase_reg;
        code_mid       = code_reg;

        unique case (phase_reg)
            PH_BSLASH:
            begin
                phase_mid = PH_PLAIN;
                priority if (in_char == CH_LOWER_X || in_char == CH_UPPER_X)
                begin
                    phase_mid = PH_RAW1;
                end
                else if (is_octal)
                begin
                    code_mid  = {3'd0, digit};
                    phase_mid = PH_OCT1;
                end
                else if (in_char == CH_LOWER_N)
                begin
                    {group.chars[0], group.chars[1]} = hex_pair(CODE_NEWLINE);
                    group.count = 3'd2;
                end
                else if (in_char == CH_LOWER_T)
                begin
                    {group.chars[0], group.chars[1]} = hex_pair(CODE_TAB);
                    group.count = 3'd2;
                end
                else
                begin
                    {group.chars[0], group.chars[1]} = hex_in;
                    group.count = 3'd2;
                end
            end
            PH_RAW1:
            begin
                group.chars[0] = in_char;
                group.count    = 3'd1;
                phase_mid      = PH_RAW2;
            end
            PH_RAW2:
            begin
                group.chars[0] = in_char;
                group.count    = 3'd1;
                phase_mid      = PH_PLAIN;
            end
            PH_OCT1, PH_OCT2:
            begin
                priority if (is_octal && phase_reg == PH_OCT1)
                begin
                    code_mid  = {code_reg[2:0], digit};
                    phase_mid = PH_OCT2;
                end
                else if (is_octal)
                begin
                    {group.chars[0], group.chars[1]} = hex_third;
                    group.count = 3'd2;
                    code_mid    = 6'd0;
                    phase_mid   = PH_PLAIN;
                end
                else
                begin
                    // The pending code goes out first, then the byte as plain text.
                    {group.chars[0], group.chars[1]} = hex_code;
                    code_mid = 6'd0;
                    if (in_char == CH_BACKSLASH)
                    begin
                        group.count = 3'd2;
                        phase_mid   = PH_BSLASH;
                    end
                    else
                    begin
                        {group.chars[2], group.chars[3]} = hex_in;
                        group.count = 3'd4;
                        phase_mid   = PH_PLAIN;
                    end
                end
            end
            default:
            begin
                if (in_char == CH_BACKSLASH)
                begin
                    phase_mid = PH_BSLASH;
                end
                else
                begin
                    {group.chars[0], group.chars[1]} = hex_in;
                    group.count = 3'd2;
                    phase_mid   = PH_PLAIN;
                end
            end
        endcase

        // End of text flushes a pending octal code and drops other escapes.
        phase_next = phase_mid;
        code_next  = code_mid;
        if (text_end)
        begin
            if (phase_mid == PH_OCT1 || phase_mid == PH_OCT2)
            begin
                {group.chars[0], group.chars[1]} = hex_flush;
                group.count = 3'd2;
            end
            phase_next = PH_PLAIN;
            code_next  = 6'd0;
        end
    end

    // Escape state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PLAIN;
            code_reg  <= 6'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            code_reg  <= code_next;
        end
    end

endmodule

FILE: hw/rtl/escape_sequence_hex_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence hex encoder
// Resolves C-style escapes in a byte stream and emits each resolved byte as
// two uppercase hex characters; raw bytes after a hex escape are copied.
// ----------------------------------------------------------------------------
// Usage:
//   char_stream carries one text byte per transfer, with text_end on the
//   final byte of a text. hex_stream carries one output character per
//   transfer; run_last marks the last character caused by an input byte and
//   text_last the last character of the text.
//   A byte is decoded in the cycle it is accepted into a group register of up
//   to four characters; the group register then passes its characters in
//   order to the output register.
//   The output register sends one character per cycle while the receiver
//   is ready. A plain byte or an escape produces two characters, a raw
//   copied byte one, and a plain byte that ends an octal run four. A byte
//   that produces nothing (a backslash, an octal digit still gathering)
//   leaves no group to send. The next byte is taken in the cycle the last
//   character of the current group moves to the output register.
//   Reset clears the escape phase, the octal code and both valid flags.
//   When the receiver stalls, the output register holds and the group
//   register fills, after which char_stream.ready drops.
// ----------------------------------------------------------------------------
module escape_sequence_hex_encoder (
    input  logic         clk,
    input  logic         rst_n,
    eshex_in_if.sink     char_stream,
    eshex_out_if.source  hex_stream
);
    import eshex_pkg::*;

    eshex_group_t group;
    logic         accept;

    logic         pend_valid_reg, pend_valid_next;
    logic [1:0]   pend_idx_reg, pend_idx_next;
    eshex_group_t pend_reg;

    logic         out_valid_reg, out_valid_next;
    logic [7:0]   out_char_reg;
    logic         run_last_reg;
    logic         text_last_reg;

    logic         out_free;
    logic         move;
    logic         at_last;
    logic         move_last;

    // Escape decoding and state.
    eshex_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_char  (char_stream.in_char),
        .text_end (char_stream.text_end),
        .group    (group)
    );

    // Handshake and serializer control.
    assign out_free  = !out_valid_reg || hex_stream.ready;
    assign move      = pend_valid_reg && out_free;
    assign at_last   = ({1'b0, pend_idx_reg} + 3'd1) == pend_reg.count;
    assign move_last = move && at_last;
    assign char_stream.ready = !pend_valid_reg || move_last;
    assign accept    = char_stream.valid && char_stream.ready;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        if (accept)
        begin
            pend_valid_next = (group.count != 3'd0);
            pend_idx_next   = 2'd0;
        end
        else if (move_last)
        begin
            pend_valid_next = 1'b0;
        end
        else if (move)
        begin
            pend_idx_next = pend_idx_reg + 2'd1;
        end

        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (hex_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Group and output payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= group;
        end
        if (move)
        begin
            out_char_reg  <= pend_reg.chars[pend_idx_reg];
            run_last_reg  <= at_last;
            text_last_reg <= at_last && pend_reg.text_end;
        end
    end

    assign hex_stream.valid     = out_valid_reg;
    assign hex_stream.out_char  = out_char_reg;
    assign hex_stream.run_last  = run_last_reg;
    assign hex_stream.text_last = text_last_reg;

`ifndef SYNTHESIS
    // The read position always stays inside the held group.
    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (({1'b0, pend_idx_reg} < pend_reg.count)
                            && (pend_reg.count <= 3'd4)))
        else $error("group read position outside the group");

    // A new byte only replaces a group whose last character leaves now.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pend_valid_reg) |-> (move && at_last))
        else $error("group overwritten before it was sent");

    // The end of a text is always also the end of a run.
    a_text_last_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && text_last_reg) |-> run_last_reg)
        else $error("text_last without run_last");

    // A moved character shows at the output in the next cycle.
    a_move_shows: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> out_valid_reg)
        else $error("moved character not presented");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence hex encoder testbench
// Drives escaped text into the encoder, predicts the hex characters that each
// accepted byte must produce and checks every output transfer in order.
// Directed texts cover the byte extremes, every escape form and the dangling
// cases at the end of a text. Random texts follow, mostly well-formed escape
// sequences with random content, under random idling on both channels and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import eshex_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [7:0] CH_SEVEN = CH_ZERO + 8'd7;

    // One expected output character with its framing flags.
    typedef struct {
        logic [7:0] out_char;
        logic       run_last;
        logic       text_last;
    } hex_char_t;

    logic clk;
    logic rst_n;

    eshex_in_if  char_if ();
    eshex_out_if hex_if ();

    escape_sequence_hex_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_if),
        .hex_stream  (hex_if)
    );

    // Predictor state.
    eshex_phase_t dec_phase;
    logic [8:0]   octal_acc;
    logic [7:0]   byte_chars[$];
    hex_char_t    hex_chars_due[$];

    int  error_count;
    int  bytes_sent;
    int  cycle_count;
    bit  src_idle_on;
    bit  sink_idle_on;
    bit  hold_off_req;

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Cycle limit guards against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("escape_sequence_hex_encoder: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic logic [7:0] nibble_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return CH_ZERO + {4'd0, nib};
        end
        return CH_ALPHA_OFS + {4'd0, nib};
    endfunction

    function automatic bit is_octal_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

    // Append one character to the characters of the current byte.
    function automatic void append_char(input logic [7:0] c);
        byte_chars.insert(byte_chars.size(), c);
    endfunction

    function automatic void add_hex_pair(input logic [7:0] b);
        append_char(nibble_char(b[7:4]));
        append_char(nibble_char(b[3:0]));
    endfunction

    // A byte seen outside any escape: a backslash opens one, anything else is encoded.
    function automatic void take_plain(input logic [7:0] c);
        if (c == CH_BACKSLASH)
        begin
            dec_phase = PH_BSLASH;
        end
        else
        begin
            add_hex_pair(c);
        end
    endfunction

    // Advance the decoder by one byte and queue the characters it produces.
    function automatic void encode_byte(input logic [7:0] c, input logic last_byte);
        logic [2:0] digit;
        hex_char_t  hc;
        digit = 3'(c - CH_ZERO);
        byte_chars.delete();
        case (dec_phase)
            PH_BSLASH:
            begin
                dec_phase = PH_PLAIN;
                if (c == CH_LOWER_X || c == CH_UPPER_X)
                begin
                    dec_phase = PH_RAW1;
                end
                else if (is_octal_digit(c))
                begin
                    octal_acc = {6'd0, digit};
                    dec_phase = PH_OCT1;
                end
                else if (c == CH_LOWER_N)
                begin
                    add_hex_pair(CODE_NEWLINE);
                end
                else if (c == CH_LOWER_T)
                begin
                    add_hex_pair(CODE_TAB);
                end
                else
                begin
                    add_hex_pair(c);
                end
            end
            PH_RAW1:
            begin
                append_char(c);
                dec_phase = PH_RAW2;
            end
            PH_RAW2:
            begin
                append_char(c);
                dec_phase = PH_PLAIN;
            end
            PH_OCT1:
            begin
                if (is_octal_digit(c))
                begin
                    octal_acc = {octal_acc[5:0], digit};
                    dec_phase = PH_OCT2;
                end
                else
                begin
                    // The pending code goes out before the byte that ended the run.
                    add_hex_pair(octal_acc[7:0]);
                    octal_acc = '0;
                    dec_phase = PH_PLAIN;
                    take_plain(c);
                end
            end
            PH_OCT2:
            begin
                dec_phase = PH_PLAIN;
                if (is_octal_digit(c))
                begin
                    octal_acc = {octal_acc[5:0], digit};
                    add_hex_pair(octal_acc[7:0]);
                    octal_acc = '0;
                end
                else
                begin
                    add_hex_pair(octal_acc[7:0]);
                    octal_acc = '0;
                    take_plain(c);
                end
            end
            default:
            begin
                dec_phase = PH_PLAIN;
                take_plain(c);
            end
        endcase

        // End of text flushes a pending octal code and drops any other partial escape.
        if (last_byte)
        begin
            if (dec_phase == PH_OCT1 || dec_phase == PH_OCT2)
            begin
                add_hex_pair(octal_acc[7:0]);
            end
            octal_acc = '0;
            dec_phase = PH_PLAIN;
        end

        foreach (byte_chars[i])
        begin
            hc.out_char  = byte_chars[i];
            hc.run_last  = (i == byte_chars.size() - 1);
            hc.text_last = (i == byte_chars.size() - 1) && last_byte;
            hex_chars_due.insert(hex_chars_due.size(), hc);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin : check_hex_chars
        hex_char_t want;
        if (rst_n && hex_if.valid && hex_if.ready)
        begin
            if (hex_chars_due.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, actual char %h %s %b %s %b",
                         $time, hex_if.out_char, "run_last", hex_if.run_last,
                         "text_last", hex_if.text_last);
                error_count = error_count + 1;
            end
            else
            begin
                want = hex_chars_due.pop_front();
                if (hex_if.out_char !== want.out_char)
                begin
                    $display("%0t: out_char expected %h actual %h",
                             $time, want.out_char, hex_if.out_char);
                    error_count = error_count + 1;
                end
                if (hex_if.run_last !== want.run_last)
                begin
                    $display("%0t: run_last expected %b actual %b",
                             $time, want.run_last, hex_if.run_last);
                    error_count = error_count + 1;
                end
                if (hex_if.text_last !== want.text_last)
                begin
                    $display("%0t: text_last expected %b actual %b",
                             $time, want.text_last, hex_if.text_last);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------------

    initial
    begin : hex_sink
        int burst;
        forever
        begin
            if (hold_off_req)
            begin
                hex_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 4) == 0)
            begin
                hex_if.ready <= 1'b0;
                burst = $urandom_range(1, 5);
                repeat (burst) @(posedge clk);
            end
            else
            begin
                hex_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offer one text byte and hold it until the transfer completes.
    task automatic send_byte(input logic [7:0] c, input logic last_byte);
        int gap;
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            char_if.valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge clk);
        end
        char_if.valid    <= 1'b1;
        char_if.in_char  <= c;
        char_if.text_end <= last_byte;
        @(posedge clk);
        while (!char_if.ready)
        begin
            @(posedge clk);
        end
        encode_byte(c, last_byte);
        bytes_sent = bytes_sent + 1;
    endtask

    // Stop offering bytes and wait until every predicted character is out.
    task automatic wait_drain();
        char_if.valid <= 1'b0;
        while (hex_chars_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One random item of text; text_end lands on a random byte now and then.
    task automatic send_random_sequence();
        int         kind;
        int         ndig;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            // Plain byte, anything but a backslash.
            c = 8'($urandom_range(0, 255));
            if (c == CH_BACKSLASH)
            begin
                c = c + 8'd1;
            end
            send_byte(c, $urandom_range(0, 19) == 0);
        end
        else if (kind < 45)
        begin
            // Simple escape: newline, tab or an arbitrary byte.
            send_byte(CH_BACKSLASH, 1'b0);
            case ($urandom_range(0, 2))
                0: c = CH_LOWER_N;
                1: c = CH_LOWER_T;
                default: c = 8'($urandom_range(0, 255));
            endcase
            send_byte(c, $urandom_range(0, 19) == 0);
        end
        else if (kind < 60)
        begin
            // Hex escape with two raw bytes.
            send_byte(CH_BACKSLASH, 1'b0);
            send_byte($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X, $urandom_range(0, 29) == 0);
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        end
        else if (kind < 85)
        begin
            // Octal escape of one to three digits, then sometimes a random byte.
            send_byte(CH_BACKSLASH, 1'b0);
            ndig = $urandom_range(1, 3);
            for (int i = 0; i < ndig; i++)
            begin
                send_byte(CH_ZERO + 8'($urandom_range(0, 7)), $urandom_range(0, 14) == 0);
            end
            if ($urandom_range(0, 1))
            begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
            end
        end
        else
        begin
            // Noise: any byte, backslash included, ending the text more often.
            c = $urandom_range(0, 3) == 0 ? CH_BACKSLASH : 8'($urandom_range(0, 255));
            send_byte(c, $urandom_range(0, 4) == 0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_plain_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_simple_escapes();
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_LOWER_N, 1'b0);
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_LOWER_T, 1'b0);
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_raw_copy();
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_LOWER_X, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_UPPER_X, 1'b0);
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(8'h41, 1'b0);
    endtask

    task automatic test_octal_runs();
        // Single digit ended by a plain byte.
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_ZERO + 8'd3, 1'b0);
        send_byte(8'h41, 1'b0);
        // Three digits with the code masked to a byte.
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_SEVEN, 1'b0);
        send_byte(CH_SEVEN, 1'b0);
        send_byte(CH_SEVEN, 1'b0);
        // Two digits still pending when the text ends.
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_ZERO + 8'd1, 1'b0);
        send_byte(CH_ZERO + 8'd2, 1'b1);
    endtask

    task automatic test_dangling_escapes();
        // Lone backslash at the end of a text produces nothing.
        send_byte(CH_BACKSLASH, 1'b1);
        // Unfinished hex escape at the end of a text is dropped.
        send_byte(CH_BACKSLASH, 1'b0);
        send_byte(CH_LOWER_X, 1'b1);
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic test_random_text(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target)
        begin
            send_random_sequence();
        end
    endtask

    // Receiver holds off while the sender keeps offering bytes.
    task automatic test_backpressure();
        bit saved_idle;
        saved_idle   = src_idle_on;
        src_idle_on  = 1'b0;
        hold_off_req = 1'b1;
        test_random_text(40);
        src_idle_on  = saved_idle;
        wait_drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        error_count      = 0;
        bytes_sent       = 0;
        cycle_count      = 0;
        src_idle_on      = 1'b1;
        sink_idle_on     = 1'b1;
        hold_off_req     = 1'b0;
        dec_phase        = PH_PLAIN;
        octal_acc        = '0;
        rst_n            <= 1'b0;
        char_if.valid    <= 1'b0;
        char_if.in_char  <= 8'h00;
        char_if.text_end <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_bytes();
        test_simple_escapes();
        test_raw_copy();
        test_octal_runs();
        test_dangling_escapes();
        test_random_text(340);
        test_backpressure();

        // Last stretch runs at full rate on both sides.
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random_text(60);

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && hex_chars_due.size() == 0)
        begin
            $display("escape_sequence_hex_encoder: match");
        end
        else
        begin
            $display("escape_sequence_hex_encoder: mismatch");
        end
        $finish;
    end

endmodule

FILE: escape_sequence_hex_encoder.f
hw/rtl/eshex_pkg.sv
hw/rtl/eshex_in_if.sv
hw/rtl/eshex_out_if.sv
hw/rtl/eshex_decode.sv
hw/rtl/escape_sequence_hex_encoder.sv
dv/tb_top.sv
